### sv/wsp_pkg.sv
`default_nettype none

package wsp_pkg;

    // fixed field widths
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 4;
    localparam int MAT_DEPTH = 16;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 1;

    // ndc magnitude is clamped to 2**NDC_BITS
    localparam int NDC_BITS = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WINDOW_WIDTH_RESET  = 14'd640;
    localparam logic [CFG_W-1:0] WINDOW_HEIGHT_RESET = 14'd480;

    // operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

endpackage

`default_nettype wire

### sv/world_to_screen_projection_top.sv
`default_nettype none

// World-to-screen projection in signed fixed point with FRAC_BITS fraction bits. A beat with
// operation 0 writes one entry of the column-major 4x4 matrix and gives no result; a beat with
// operation 1 projects (pos_x, pos_y, pos_z, 1) and gives one result. One beat is taken every
// cycle; the pipeline stalls as a whole only while a result waits on m_ready. The 20-stage
// divider (two quotient bits per stage) forms x/w and y/w. Points below w = 0.1 come out with
// visible low and zero coordinates. Load the matrix entries a projection uses before sending it;
// the user must write window size only while idle, which the block does not enforce.
module world_to_screen_projection_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire [wsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [wsp_pkg::CFG_W-1:0]          cfg_data,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire                               s_operation,
    input  wire [wsp_pkg::IDX_W-1:0]          s_matrix_index,
    input  wire signed [wsp_pkg::DATA_W-1:0]  s_matrix_value,
    input  wire signed [wsp_pkg::DATA_W-1:0]  s_pos_x,
    input  wire signed [wsp_pkg::DATA_W-1:0]  s_pos_y,
    input  wire signed [wsp_pkg::DATA_W-1:0]  s_pos_z,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic                              m_visible,
    output logic signed [wsp_pkg::DATA_W-1:0] m_screen_x,
    output logic signed [wsp_pkg::DATA_W-1:0] m_screen_y
);

    localparam int DW       = wsp_pkg::DATA_W;
    localparam int NB       = wsp_pkg::NDC_BITS;
    localparam int PW       = 2 * DW;
    localparam int SW       = 2 * DW - FRAC_BITS + 2;
    localparam int RW       = SW + 1;
    localparam int DIV_STEP = 2;
    localparam int DIV_STG  = NB / DIV_STEP;
    localparam int HW       = wsp_pkg::CFG_W - 1;
    localparam int MW       = HW + 1 + NB + 2;
    localparam int EW       = MW + 2;
    localparam int W_MIN_I  = ((1 << FRAC_BITS) + 5) / 10;
    localparam logic signed [SW-1:0] W_MIN = SW'(W_MIN_I);

    typedef struct packed {
        logic [RW-1:0] rem_x;
        logic [RW-1:0] rem_y;
        logic [NB-1:0] lo_x;
        logic [NB-1:0] lo_y;
        logic [NB-1:0] q_x;
        logic [NB-1:0] q_y;
        logic [SW-1:0] w;
        logic          vis;
        logic          neg_x;
        logic          neg_y;
        logic          clamp_x;
        logic          clamp_y;
    } div_t;

    logic signed [DW-1:0] matrix_reg [wsp_pkg::MAT_DEPTH];
    logic [wsp_pkg::CFG_W-1:0] win_w_reg, win_h_reg;
    logic [HW-1:0] half_w, half_h;

    logic advance, accept;

    // stage a: products and translation snapshot
    logic                 a_vld_reg;
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [DW-1:0] trans_reg [3];

    // stage b: clip coordinates
    logic                 b_vld_reg;
    logic signed [SW-1:0] clip_reg [3];

    // divider stages
    logic       d_vld_reg [DIV_STG+1];
    div_t       div_reg   [DIV_STG+1];

    // stage e: viewport products
    logic                 e_vld_reg, e_vis_reg;
    logic signed [MW-1:0] pm_x_reg, pm_y_reg;

    logic                 m_valid_reg, m_visible_reg;
    logic signed [DW-1:0] m_x_reg, m_y_reg;

    assign advance = !(m_valid_reg && !m_ready);
    assign s_ready = advance;
    assign accept  = s_valid && advance;
    assign half_w  = win_w_reg[wsp_pkg::CFG_W-1:1];
    assign half_h  = win_h_reg[wsp_pkg::CFG_W-1:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_w_reg <= wsp_pkg::WINDOW_WIDTH_RESET;
            win_h_reg <= wsp_pkg::WINDOW_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wsp_pkg::REG_WINDOW_WIDTH:  win_w_reg <= cfg_data;
                wsp_pkg::REG_WINDOW_HEIGHT: win_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_operation == wsp_pkg::OP_LOAD) begin
            matrix_reg[s_matrix_index] <= s_matrix_value;
        end
    end

    // rows 0, 1 and 3 of the matrix give clip x, y and w
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int r = 0; r < 3; r++) begin
                prod_reg[r][0] <= s_pos_x * matrix_reg[(r == 2) ? 3 : r];
                prod_reg[r][1] <= s_pos_y * matrix_reg[4 + ((r == 2) ? 3 : r)];
                prod_reg[r][2] <= s_pos_z * matrix_reg[8 + ((r == 2) ? 3 : r)];
                trans_reg[r]   <= matrix_reg[12 + ((r == 2) ? 3 : r)];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int r = 0; r < 3; r++) begin
                clip_reg[r] <= SW'(prod_reg[r][0] >>> FRAC_BITS)
                             + SW'(prod_reg[r][1] >>> FRAC_BITS)
                             + SW'(prod_reg[r][2] >>> FRAC_BITS)
                             + SW'(trans_reg[r]);
            end
        end
    end

    // stage c: magnitudes, first remainder and overflow check
    logic [SW-1:0]         mag_x, mag_y;
    logic [SW+FRAC_BITS-1:0] num_x, num_y;
    div_t                  div_first;

    always_comb begin
        mag_x = clip_reg[0][SW-1] ? SW'(-clip_reg[0]) : SW'(clip_reg[0]);
        mag_y = clip_reg[1][SW-1] ? SW'(-clip_reg[1]) : SW'(clip_reg[1]);
        num_x = {mag_x, {FRAC_BITS{1'b0}}};
        num_y = {mag_y, {FRAC_BITS{1'b0}}};
        div_first.rem_x   = RW'(mag_x >> (NB - FRAC_BITS));
        div_first.rem_y   = RW'(mag_y >> (NB - FRAC_BITS));
        div_first.lo_x    = num_x[NB-1:0];
        div_first.lo_y    = num_y[NB-1:0];
        div_first.q_x     = '0;
        div_first.q_y     = '0;
        div_first.w       = clip_reg[2];
        div_first.vis     = clip_reg[2] >= W_MIN;
        div_first.neg_x   = clip_reg[0][SW-1];
        div_first.neg_y   = clip_reg[1][SW-1];
        div_first.clamp_x = div_first.rem_x >= RW'(clip_reg[2]);
        div_first.clamp_y = div_first.rem_y >= RW'(clip_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            div_reg[0] <= div_first;
        end
    end

    // restoring division, DIV_STEP quotient bits per stage
    for (genvar k = 1; k <= DIV_STG; k++) begin : g_div
        div_t step_next;

        always_comb begin
            logic [RW-1:0] rt;
            step_next = div_reg[k-1];
            for (int j = 0; j < DIV_STEP; j++) begin
                rt = {step_next.rem_x[RW-2:0], step_next.lo_x[NB-1]};
                step_next.lo_x = {step_next.lo_x[NB-2:0], 1'b0};
                if (rt >= RW'(step_next.w)) begin
                    step_next.rem_x = rt - RW'(step_next.w);
                    step_next.q_x   = {step_next.q_x[NB-2:0], 1'b1};
                end else begin
                    step_next.rem_x = rt;
                    step_next.q_x   = {step_next.q_x[NB-2:0], 1'b0};
                end
                rt = {step_next.rem_y[RW-2:0], step_next.lo_y[NB-1]};
                step_next.lo_y = {step_next.lo_y[NB-2:0], 1'b0};
                if (rt >= RW'(step_next.w)) begin
                    step_next.rem_y = rt - RW'(step_next.w);
                    step_next.q_y   = {step_next.q_y[NB-2:0], 1'b1};
                end else begin
                    step_next.rem_y = rt;
                    step_next.q_y   = {step_next.q_y[NB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                div_reg[k] <= step_next;
            end
        end
    end

    // stage e: signed ndc times half window
    div_t                 dl;
    logic [NB:0]          qm_x, qm_y;
    logic signed [NB+1:0] ndc_x, ndc_y;

    always_comb begin
        dl    = div_reg[DIV_STG];
        qm_x  = dl.clamp_x ? {1'b1, {NB{1'b0}}} : {1'b0, dl.q_x};
        qm_y  = dl.clamp_y ? {1'b1, {NB{1'b0}}} : {1'b0, dl.q_y};
        ndc_x = dl.neg_x ? -$signed({1'b0, qm_x}) : $signed({1'b0, qm_x});
        ndc_y = dl.neg_y ? -$signed({1'b0, qm_y}) : $signed({1'b0, qm_y});
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            e_vis_reg <= dl.vis;
            pm_x_reg  <= $signed({1'b0, half_w}) * ndc_x;
            pm_y_reg  <= $signed({1'b0, half_h}) * ndc_y;
        end
    end

    // output stage: offset, saturate, blank when not visible
    logic signed [EW-1:0] sum_x, sum_y;
    logic signed [DW-1:0] sat_x, sat_y;
    localparam logic signed [EW-1:0] SAT_HI = EW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [EW-1:0] SAT_LO = -EW'({1'b0, {(DW-1){1'b1}}}) - EW'(1);

    always_comb begin
        sum_x = (EW'(half_w) <<< FRAC_BITS) + EW'(pm_x_reg);
        sum_y = (EW'(half_h) <<< FRAC_BITS) - EW'(pm_y_reg);
        if (sum_x > SAT_HI)      sat_x = SAT_HI[DW-1:0];
        else if (sum_x < SAT_LO) sat_x = SAT_LO[DW-1:0];
        else                     sat_x = sum_x[DW-1:0];
        if (sum_y > SAT_HI)      sat_y = SAT_HI[DW-1:0];
        else if (sum_y < SAT_LO) sat_y = SAT_LO[DW-1:0];
        else                     sat_y = sum_y[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_visible_reg <= e_vis_reg;
            m_x_reg       <= e_vis_reg ? sat_x : '0;
            m_y_reg       <= e_vis_reg ? sat_y : '0;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i <= DIV_STG; i++) d_vld_reg[i] <= 1'b0;
        end else if (advance) begin
            a_vld_reg   <= accept && s_operation == wsp_pkg::OP_PROJECT;
            b_vld_reg   <= a_vld_reg;
            d_vld_reg[0] <= b_vld_reg;
            for (int i = 1; i <= DIV_STG; i++) d_vld_reg[i] <= d_vld_reg[i-1];
            e_vld_reg   <= d_vld_reg[DIV_STG];
            m_valid_reg <= e_vld_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_visible  = m_visible_reg;
    assign m_screen_x = m_x_reg;
    assign m_screen_y = m_y_reg;

`ifndef SYNTHESIS
    a_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |-> m_screen_x == '0 && m_screen_y == '0)
        else $error("hidden point has nonzero coordinates");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        e_vld_reg && !s_ready |=> e_vld_reg && $stable(pm_x_reg))
        else $error("stage lost data during stall");
    a_zero_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible && half_w == '0 |-> m_screen_x == '0)
        else $error("zero half width gave nonzero x");
    a_no_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == wsp_pkg::OP_LOAD |=> !a_vld_reg)
        else $error("load beat entered the pipeline");
`endif

endmodule

`default_nettype wire
